FILE: rtl/fpta_pkg.sv
// ----------------------------------------------------------------------------
// fpta_pkg: shared types and constants for the temperature formatter
// Holds the payload structs, the sequencer states, the character codes
// and the fixed-point scaling constants.
// ----------------------------------------------------------------------------
package fpta_pkg;

    // Fixed-point scaling: internal value counts 2^-FRAC_BITS degrees
    localparam int FRAC_BITS  = 2;
    localparam int RAW_W      = 16;
    localparam int FB_W       = 4;
    localparam int SCALE_W    = RAW_W + FRAC_BITS;          // shifted raw value
    localparam int VAL_W      = 15;                         // clamped value
    localparam int LIMIT      = 2048 * (1 << FRAC_BITS);
    localparam int PROD_W     = VAL_W + 4;                  // value times 18
    localparam int TENTHS_W   = 17;                         // Fahrenheit tenths
    localparam int BIN_W      = 16;                         // converter input
    localparam int BCD_W      = 20;                         // five BCD digits
    localparam int CONV_STEPS = BIN_W;
    localparam int NUM_SLOTS  = 7;
    localparam int F_OFFSET   = 320;

    // Character codes
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_FIVE  = 8'h35;
    localparam logic [7:0] CH_F     = 8'h46;

    // Character slots of one reading
    localparam logic [2:0] SLOT_SIGN  = 3'd0;
    localparam logic [2:0] SLOT_THOU  = 3'd1;
    localparam logic [2:0] SLOT_HUND  = 3'd2;
    localparam logic [2:0] SLOT_TENS  = 3'd3;
    localparam logic [2:0] SLOT_ONES  = 3'd4;
    localparam logic [2:0] SLOT_TAIL  = 3'd5;
    localparam logic [2:0] SLOT_HALF  = 3'd6;

    // Display unit codes
    localparam logic UNIT_CELSIUS    = 1'b0;
    localparam logic UNIT_FAHRENHEIT = 1'b1;

    typedef struct packed {
        logic signed [RAW_W-1:0] raw_value;
        logic [FB_W-1:0]         fraction_bits;
    } in_item_t;

    typedef struct packed {
        logic [7:0] ascii_char;
        logic       last_char;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_FORM,
        ST_CONV,
        ST_EMIT
    } state_t;

    // Add three to every BCD digit of five or more (one double-dabble step)
    function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
        logic [BCD_W-1:0] res;
        res = bcd;
        for (int i = 0; i < BCD_W / 4; i++)
        begin
            if (bcd[i*4 +: 4] >= 4'd5)
            begin
                res[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
            end
        end
        return res;
    endfunction

endpackage

FILE: rtl/fixed_point_temp_to_ascii_top.sv
// ----------------------------------------------------------------------------
// fixed_point_temp_to_ascii_top: fixed-point temperature to ASCII formatter
// Rescales a signed reading to quarter degrees, clamps it to +/-2048 degrees
// and sends its characters out one per transfer, in Celsius with a half-degree
// digit or in whole Fahrenheit.
//
// Channel  Dir  Handshake             Payload
// in       in   in_valid / in_stall   in_data  (raw_value, fraction_bits)
// out      out  out_valid / out_stall out_data (ascii_char, last_char)
// cfg      in   cfg_wr_en             cfg_wr_data (display_unit)
//
// A reading keeps the sequencer busy, and any output stall prolongs it: a
// scale step, a format step, 16 steps of the shared double-dabble shift/add-3
// unit and then one step per character slot (7 in Celsius, 6 in Fahrenheit;
// a blank slot is still stepped through). The sequencer returns to idle
// before it takes the next reading.
// Reset selects Celsius and idles the sequencer.
// in_stall stays high from input transfer until the last character is loaded
// into the output register; out_stall holds the output register.
// ----------------------------------------------------------------------------
module fixed_point_temp_to_ascii_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  fpta_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output fpta_pkg::out_item_t out_data,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data
);
    import fpta_pkg::*;

    // Control registers
    state_t                state_reg, state_next;
    logic [3:0]            cnt_reg, cnt_next;
    logic [2:0]            slot_reg, slot_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  unit_reg;

    // Datapath registers
    in_item_t              in_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic                  neg_reg;
    logic                  half_reg;
    logic [BIN_W-1:0]      bin_reg;
    logic [BCD_W-1:0]      bcd_reg;
    out_item_t             out_reg, out_next;

    // Sequencer strobes
    logic                  in_xfer;
    logic                  out_free;
    logic                  slot_en;
    logic                  slot_last;
    logic                  advance;
    logic                  load_out;
    logic                  conv_done;

    // Scale and clamp
    logic signed [SCALE_W-1:0] scale_ext;
    logic signed [SCALE_W-1:0] scaled;
    logic signed [VAL_W-1:0]   clamped;

    // Format
    logic signed [PROD_W-1:0]   val_ext;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   prod_q;
    logic signed [TENTHS_W-1:0] tenths;
    logic                       form_neg;
    logic [BIN_W-1:0]           form_bin;
    logic                       form_half;
    logic [VAL_W-1:0]           c_mag;
    logic [TENTHS_W-1:0]        f_mag;

    // Conversion and emission
    logic [BIN_W+BCD_W-1:0] dd_shift;
    logic [3:0]             dig_thou, dig_hund, dig_tens, dig_ones;
    logic [NUM_SLOTS-1:0]   slot_mask;
    logic [NUM_SLOTS-1:0]   above_mask;
    logic [7:0]             slot_char;

    // ------------------------------------------------------------------
    // Scale to quarter degrees with a floor shift, then clamp
    // ------------------------------------------------------------------
    always_comb
    begin
        scale_ext = {in_reg.raw_value, {FRAC_BITS{1'b0}}};
        scaled    = scale_ext >>> in_reg.fraction_bits;
        if (scaled > SCALE_W'(LIMIT))
        begin
            clamped = VAL_W'(LIMIT);
        end
        else if (scaled < -SCALE_W'(LIMIT))
        begin
            clamped = -VAL_W'(LIMIT);
        end
        else
        begin
            clamped = scaled[VAL_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Form sign and magnitude for the selected unit
    // ------------------------------------------------------------------
    always_comb
    begin
        val_ext = PROD_W'(val_reg);
        prod    = (val_ext <<< 4) + (val_ext <<< 1);
        prod_q  = prod >>> FRAC_BITS;
        tenths  = prod_q[TENTHS_W-1:0] + TENTHS_W'(F_OFFSET);
        c_mag   = val_reg[VAL_W-1] ? VAL_W'(-val_reg) : VAL_W'(val_reg);
        f_mag   = tenths[TENTHS_W-1] ? TENTHS_W'(-tenths) : TENTHS_W'(tenths);
        if (unit_reg == UNIT_FAHRENHEIT)
        begin
            form_neg  = tenths[TENTHS_W-1];
            form_bin  = f_mag[BIN_W-1:0];
            form_half = 1'b0;
        end
        else
        begin
            form_neg  = val_reg[VAL_W-1];
            form_bin  = BIN_W'(c_mag >> FRAC_BITS);
            form_half = c_mag[FRAC_BITS-1];
        end
    end

    // ------------------------------------------------------------------
    // Pick digits and build the slot mask and slot character
    // ------------------------------------------------------------------
    always_comb
    begin
        dd_shift = {bcd_adjust(bcd_reg), bin_reg} << 1;
        // Fahrenheit drops the tenths digit
        if (unit_reg == UNIT_FAHRENHEIT)
        begin
            dig_thou = bcd_reg[19:16];
            dig_hund = bcd_reg[15:12];
            dig_tens = bcd_reg[11:8];
            dig_ones = bcd_reg[7:4];
        end
        else
        begin
            dig_thou = bcd_reg[15:12];
            dig_hund = bcd_reg[11:8];
            dig_tens = bcd_reg[7:4];
            dig_ones = bcd_reg[3:0];
        end
        slot_mask[SLOT_SIGN] = neg_reg;
        slot_mask[SLOT_THOU] = (dig_thou != 4'd0);
        slot_mask[SLOT_HUND] = slot_mask[SLOT_THOU] || (dig_hund != 4'd0);
        slot_mask[SLOT_TENS] = slot_mask[SLOT_HUND] || (dig_tens != 4'd0);
        slot_mask[SLOT_ONES] = 1'b1;
        slot_mask[SLOT_TAIL] = 1'b1;
        slot_mask[SLOT_HALF] = (unit_reg == UNIT_CELSIUS);
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            above_mask[i] = (3'(i) > slot_reg);
        end
        case (slot_reg)
            SLOT_SIGN: slot_char = CH_MINUS;
            SLOT_THOU: slot_char = CH_ZERO + {4'd0, dig_thou};
            SLOT_HUND: slot_char = CH_ZERO + {4'd0, dig_hund};
            SLOT_TENS: slot_char = CH_ZERO + {4'd0, dig_tens};
            SLOT_ONES: slot_char = CH_ZERO + {4'd0, dig_ones};
            SLOT_TAIL: slot_char = (unit_reg == UNIT_FAHRENHEIT) ? CH_F : CH_POINT;
            SLOT_HALF: slot_char = half_reg ? CH_FIVE : CH_ZERO;
            default:   slot_char = CH_ZERO;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        in_xfer   = in_valid && !in_stall;
        out_free  = !out_valid_reg || !out_stall;
        slot_en   = slot_mask[slot_reg];
        slot_last = ((slot_mask & above_mask) == '0);
        advance   = (state_reg == ST_EMIT) && (!slot_en || out_free);
        load_out  = (state_reg == ST_EMIT) && slot_en && out_free;
        conv_done = (state_reg == ST_CONV) && (cnt_reg == 4'(CONV_STEPS - 1));
    end

    // ------------------------------------------------------------------
    // Sequencer next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: state_next = ST_FORM;
            ST_FORM:  state_next = ST_CONV;
            ST_CONV:
            begin
                if (conv_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (advance && slot_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Counter, slot and output register next values
    // ------------------------------------------------------------------
    always_comb
    begin
        cnt_next  = cnt_reg;
        slot_next = slot_reg;
        if (state_reg == ST_FORM)
        begin
            cnt_next  = 4'd0;
            slot_next = SLOT_SIGN;
        end
        else if (state_reg == ST_CONV)
        begin
            cnt_next = cnt_reg + 4'd1;
        end
        else if (advance)
        begin
            slot_next = slot_reg + 3'd1;
        end

        out_next.ascii_char = slot_char;
        out_next.last_char  = slot_last;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 4'd0;
            slot_reg      <= SLOT_SIGN;
            out_valid_reg <= 1'b0;
            unit_reg      <= UNIT_CELSIUS;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                unit_reg <= cfg_wr_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        // Capture the input item
        if (in_xfer)
        begin
            in_reg <= in_data;
        end
        // Hold the clamped value
        if (state_reg == ST_SCALE)
        begin
            val_reg <= clamped;
        end
        // Load the converter
        if (state_reg == ST_FORM)
        begin
            neg_reg  <= form_neg;
            half_reg <= form_half;
            bin_reg  <= form_bin;
            bcd_reg  <= '0;
        end
        // Advance the double-dabble unit one bit
        if (state_reg == ST_CONV)
        begin
            bcd_reg <= dd_shift[BIN_W+BCD_W-1:BIN_W];
            bin_reg <= dd_shift[BIN_W-1:0];
        end
        // Load the next character
        if (load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    // The last character of a reading returns the sequencer to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out && slot_last |=> state_reg == ST_IDLE)
        else $error("sequencer did not finish after last character");

    // An input transfer starts the scale step
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == ST_SCALE)
        else $error("input transfer did not start a reading");

    // Conversion runs its full step count before emission
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CONV && !conv_done |=> state_reg == ST_CONV)
        else $error("conversion left early");

    // The output register only loads while emitting
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_EMIT)
        else $error("output loaded outside emission");
`endif

endmodule
